@@ rtl/bpst_pkg.sv @@
`timescale 1ns / 1ps
// Package of the breath pressure step tuner: payload structs, divider handshake
// structs, sequencer states, register indexes and tuning constants. No dependencies.
package bpst_pkg;

  // Sum width taken from the accumulated pressure sums, and the blower ceiling.
  localparam int unsigned SUM_BITS  = 24;
  localparam int unsigned LEVEL_MAX = 4095;
  localparam int unsigned LEVEL_W   = $clog2(LEVEL_MAX + 1);

  localparam int unsigned CNT_W      = 16;
  localparam int unsigned MEAN_W     = 8;
  localparam int unsigned VALVE_W    = 9;
  localparam int unsigned THRESH_W   = 8;
  localparam int unsigned HI_TGT_W   = 7;
  localparam int unsigned LO_TGT_W   = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TARGET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_TARGET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOWER_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VALVE_START     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_START = 3'd4;

  // Request kinds.
  localparam logic REQ_HIGH_PHASE = 1'b0;
  localparam logic REQ_LOW_PHASE  = 1'b1;

  // Reset values.
  localparam logic [HI_TGT_W-1:0] HIGH_TARGET_RST = 7'd20;
  localparam logic [LO_TGT_W-1:0] LOW_TARGET_RST  = 6'd5;
  localparam logic [LEVEL_W-1:0]  BLOWER_RST      = LEVEL_W'(1000);
  localparam logic [VALVE_W-1:0]  VALVE_RST       = 9'd100;
  localparam logic [THRESH_W-1:0] THRESH_RST      = 8'd10;

  // Mean limits.
  localparam logic [MEAN_W-1:0] MEAN_EMPTY = 8'd1;
  localparam logic [MEAN_W-1:0] MEAN_MAX   = 8'd255;

  // Valve and threshold tuning.
  localparam logic [VALVE_W-1:0]  VALVE_MAX     = 9'd500;
  localparam logic [VALVE_W-1:0]  VALVE_MIN     = 9'd1;
  localparam logic [VALVE_W-1:0]  VSTEP_UP_BIG  = 9'd100;
  localparam logic [VALVE_W-1:0]  VSTEP_UP_MID  = 9'd40;
  localparam logic [VALVE_W-1:0]  VSTEP_SMALL   = 9'd10;
  localparam logic [VALVE_W-1:0]  VSTEP_DN_BIG  = 9'd50;
  localparam logic [VALVE_W-1:0]  VSTEP_DN_MID  = 9'd30;
  localparam logic [VALVE_W-1:0]  BAND_WIDE     = 9'd8;
  localparam logic [VALVE_W-1:0]  BAND_NARROW   = 9'd2;
  localparam logic [THRESH_W-1:0] THRESH_FLOOR  = 8'd6;
  localparam logic [THRESH_W-1:0] THRESH_CEIL   = 8'd255;
  localparam logic [THRESH_W-1:0] THRESH_EMPTY_RISE = 8'd2;

  // Blower tuning.
  localparam logic [MEAN_W:0]    BLOW_BAND_FAR  = 9'd4;
  localparam logic [MEAN_W:0]    BLOW_BAND_NEAR = 9'd2;
  localparam logic [LEVEL_W-1:0] BSTEP_BIG      = LEVEL_W'(40);
  localparam logic [LEVEL_W-1:0] BSTEP_MID      = LEVEL_W'(20);
  localparam logic [LEVEL_W-1:0] BSTEP_SMALL    = LEVEL_W'(10);

  typedef struct packed {
    logic                req_type;
    logic [23:0]         pip_sum;
    logic [CNT_W-1:0]    pip_count;
    logic [23:0]         peep_sum;
    logic [CNT_W-1:0]    peep_count;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  blower_level;
    logic [VALVE_W-1:0]  valve_open_ms;
    logic [THRESH_W-1:0] hold_threshold_half;
    logic [MEAN_W-1:0]   pip_mean;
    logic [MEAN_W-1:0]   peep_mean;
  } out_item_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] sum;
    logic [CNT_W-1:0]    count;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [MEAN_W-1:0] mean;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIP_GO,
    ST_PIP_WAIT,
    ST_PEEP_GO,
    ST_PEEP_WAIT,
    ST_TUNE_VALVE,
    ST_TUNE_BLOWER,
    ST_DONE
  } state_t;

endpackage

@@ rtl/bpst_div.sv @@
`timescale 1ns / 1ps
// Iterative saturating mean unit: sum / count limited to eight quotient bits,
// one compare-and-subtract per cycle. Depends on bpst_pkg.
module bpst_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bpst_pkg::div_req_t req,
  output bpst_pkg::div_rsp_t rsp
);
  import bpst_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [MEAN_W-1:0]   low_r, low_nxt;
  logic [MEAN_W-1:0]   q_r, q_nxt;

  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                fits;
  logic [SUM_BITS-1:0] sum_hi;

  // Shared compare-and-subtract stage.
  assign trial  = {rem_r, low_r[MEAN_W-1]};
  assign diff   = trial - {1'b0, div_r};
  assign fits   = trial >= {1'b0, div_r};
  assign sum_hi = req.sum >> MEAN_W;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    low_nxt  = low_r;
    q_nxt    = q_r;
    if (busy_r) begin
      rem_nxt  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      q_nxt    = {q_r[MEAN_W-2:0], fits};
      low_nxt  = low_r << 1;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      if (req.sum == '0 || req.count == '0) begin
        q_nxt    = MEAN_EMPTY;
        done_nxt = 1'b1;
      end else if (sum_hi >= SUM_BITS'(req.count)) begin
        // The quotient needs more than eight bits.
        q_nxt    = MEAN_MAX;
        done_nxt = 1'b1;
      end else begin
        // The high part is below the divisor, so it is the first partial remainder.
        rem_nxt  = sum_hi[CNT_W-1:0];
        low_nxt  = req.sum[MEAN_W-1:0];
        div_nxt  = req.count;
        step_nxt = 3'd0;
        busy_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    low_r <= low_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.mean = q_r;

endmodule

@@ rtl/breath_pressure_step_tuner.sv @@
`timescale 1ns / 1ps
// Top level of the breath pressure step tuner: sequencer, tuning datapath and
// output register. Depends on bpst_pkg and bpst_div.
//
// Usage. Each input transfer on in_valid/in_stall marks the start of a breath
// phase. A high-phase item (req_type 0) divides the two pressure sums by their
// sample counts in the shared iterative mean unit, stores both means, then steps
// the expiratory valve time and the PEEP hold threshold. A low-phase item
// (req_type 1) steps the blower level from the stored high-phase mean. Every item
// gives exactly one result transfer holding the tuned state.
// A high-phase item runs each mean through the divider loop (eight compare-and-subtract
// steps per mean) unless its sum or count is zero or the mean saturates; a low-phase
// item goes straight to the blower step. One item is in work at a time, so the block
// takes no new item before it is through with the last one.
// in_stall is high while an item is in work. A finished result sits in the
// output register; the next item may be taken while it waits. If the receiver
// stalls and the register is still full when a second result is ready, the
// sequencer holds it until the register frees.
// Synchronous reset loads the targets and the start values and clears both means.
// Configuration writes to the two targets are registered; writes to the start indexes
// are ignored, since reset loads the start values as constants.
module breath_pressure_step_tuner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bpst_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bpst_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bpst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bpst_pkg::*;

  state_t              state_r, state_nxt;

  logic [HI_TGT_W-1:0] hi_target_r, hi_target_nxt;
  logic [LO_TGT_W-1:0] lo_target_r, lo_target_nxt;

  logic [LEVEL_W-1:0]  blower_r, blower_nxt;
  logic [VALVE_W-1:0]  valve_r, valve_nxt;
  logic [THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [MEAN_W-1:0]   pip_avg_r, pip_avg_nxt;
  logic [MEAN_W-1:0]   peep_avg_r, peep_avg_nxt;

  in_item_t            item_r, item_nxt;
  out_item_t           out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_xfer;
  logic                load_out;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  // Results of the two tuning steps.
  logic [VALVE_W-1:0]  valve_tuned;
  logic [THRESH_W-1:0] thresh_tuned;
  logic [LEVEL_W-1:0]  blower_tuned;

  bpst_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [THRESH_W-1:0] thresh_raise(
    input logic [THRESH_W-1:0] t,
    input logic [THRESH_W-1:0] h
  );
    logic [THRESH_W:0] s;
    s = {1'b0, t} + {1'b0, h};
    return (s > {1'b0, THRESH_CEIL}) ? THRESH_CEIL : s[THRESH_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == REQ_HIGH_PHASE) ? ST_PIP_GO : ST_TUNE_BLOWER;
        end
      end
      ST_PIP_GO:      state_nxt = ST_PIP_WAIT;
      ST_PIP_WAIT:    if (div_rsp.done) state_nxt = ST_PEEP_GO;
      ST_PEEP_GO:     state_nxt = ST_PEEP_WAIT;
      ST_PEEP_WAIT:   if (div_rsp.done) state_nxt = ST_TUNE_VALVE;
      ST_TUNE_VALVE:  state_nxt = ST_DONE;
      ST_TUNE_BLOWER: state_nxt = ST_DONE;
      ST_DONE:        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    load_out      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
    div_req.start = (state_r == ST_PIP_GO) || (state_r == ST_PEEP_GO);
    div_req.sum   = (state_r == ST_PEEP_GO) ? item_r.peep_sum[SUM_BITS-1:0]
                                            : item_r.pip_sum[SUM_BITS-1:0];
    div_req.count = (state_r == ST_PEEP_GO) ? item_r.peep_count : item_r.pip_count;
  end

  assign in_xfer = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Valve and threshold step, from the fresh low-phase mean.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [VALVE_W-1:0]  a9, s9;
    logic                go_up, go_down, is_empty;
    logic [VALVE_W-1:0]  up_step, dn_step;
    logic [VALVE_W:0]    up_sum, dn_diff;
    logic [THRESH_W-1:0] th_up, th_base;
    logic                dn_bad;

    a9       = VALVE_W'(peep_avg_r);
    s9       = VALVE_W'(lo_target_r);
    is_empty = (peep_avg_r == '0);
    go_up    = a9 > s9;
    go_down  = a9 < s9;

    if (a9 > s9 + BAND_WIDE) begin
      up_step = VSTEP_UP_BIG;
    end else if (a9 > s9 + BAND_NARROW) begin
      up_step = VSTEP_UP_MID;
    end else begin
      up_step = VSTEP_SMALL;
    end

    if (is_empty) begin
      dn_step = VSTEP_SMALL;
    end else if (a9 + BAND_WIDE < s9) begin
      dn_step = VSTEP_DN_BIG;
    end else if (a9 + BAND_NARROW < s9) begin
      dn_step = VSTEP_DN_MID;
    end else begin
      dn_step = VSTEP_SMALL;
    end

    // Opening step: clamp at the top and give back half a unit of threshold.
    up_sum = {1'b0, valve_r} + {1'b0, up_step};
    th_up  = thresh_r;
    if (up_sum >= {1'b0, VALVE_MAX}) begin
      th_up = (thresh_r != '0) ? thresh_r - 8'd1 : '0;
    end
    if (th_up <= THRESH_FLOOR) begin
      th_up = THRESH_FLOOR;
    end

    // Closing step: a result outside the valid range goes to the minimum.
    th_base = is_empty ? thresh_raise(thresh_r, THRESH_EMPTY_RISE) : thresh_r;
    dn_diff = {1'b0, valve_r} - {1'b0, dn_step};
    dn_bad  = ({1'b0, valve_r} < {1'b0, dn_step} + (VALVE_W + 1)'(VALVE_MIN)) ||
              (dn_diff > {1'b0, VALVE_MAX});

    priority if (go_up) begin
      valve_tuned  = (up_sum >= {1'b0, VALVE_MAX}) ? VALVE_MAX : up_sum[VALVE_W-1:0];
      thresh_tuned = th_up;
    end else if (is_empty || go_down) begin
      valve_tuned  = dn_bad ? VALVE_MIN : dn_diff[VALVE_W-1:0];
      thresh_tuned = (dn_bad && !is_empty) ? thresh_raise(th_base, 8'd1) : th_base;
    end else begin
      valve_tuned  = valve_r;
      thresh_tuned = thresh_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Blower step, from the stored high-phase mean.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [MEAN_W:0]    a9, p9, gap;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W:0]   up_sum;

    a9  = {1'b0, pip_avg_r};
    p9  = (MEAN_W + 1)'(hi_target_r);
    gap = (a9 > p9) ? a9 - p9 : p9 - a9;
    if (gap >= BLOW_BAND_FAR) begin
      step = BSTEP_BIG;
    end else if (gap >= BLOW_BAND_NEAR) begin
      step = BSTEP_MID;
    end else begin
      step = BSTEP_SMALL;
    end
    up_sum = {1'b0, blower_r} + {1'b0, step};

    priority if (a9 > p9) begin
      blower_tuned = (blower_r < step) ? '0 : blower_r - step;
    end else if (a9 < p9) begin
      blower_tuned = (up_sum > (LEVEL_W + 1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                          : up_sum[LEVEL_W-1:0];
    end else begin
      blower_tuned = blower_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    hi_target_nxt = hi_target_r;
    lo_target_nxt = lo_target_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_HIGH_TARGET: hi_target_nxt = cfg_wdata[HI_TGT_W-1:0];
        CFG_LOW_TARGET:  lo_target_nxt = cfg_wdata[LO_TGT_W-1:0];
        // Start values only matter at reset, which reloads them as constants.
        CFG_BLOWER_START, CFG_VALVE_START, CFG_THRESHOLD_START: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_nxt      = in_xfer ? in_data : item_r;
    blower_nxt    = blower_r;
    valve_nxt     = valve_r;
    thresh_nxt    = thresh_r;
    pip_avg_nxt   = pip_avg_r;
    peep_avg_nxt  = peep_avg_r;
    if (state_r == ST_PIP_WAIT && div_rsp.done) begin
      pip_avg_nxt = div_rsp.mean;
    end
    if (state_r == ST_PEEP_WAIT && div_rsp.done) begin
      peep_avg_nxt = div_rsp.mean;
    end
    if (state_r == ST_TUNE_VALVE) begin
      valve_nxt  = valve_tuned;
      thresh_nxt = thresh_tuned;
    end
    if (state_r == ST_TUNE_BLOWER) begin
      blower_nxt = blower_tuned;
    end

    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_data_nxt.blower_level        = blower_r;
      out_data_nxt.valve_open_ms       = valve_r;
      out_data_nxt.hold_threshold_half = thresh_r;
      out_data_nxt.pip_mean            = pip_avg_r;
      out_data_nxt.peep_mean           = peep_avg_r;
      out_valid_nxt                    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      hi_target_r <= HIGH_TARGET_RST;
      lo_target_r <= LOW_TARGET_RST;
      blower_r    <= BLOWER_RST;
      valve_r     <= VALVE_RST;
      thresh_r    <= THRESH_RST;
      pip_avg_r   <= '0;
      peep_avg_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hi_target_r <= hi_target_nxt;
      lo_target_r <= lo_target_nxt;
      blower_r    <= blower_nxt;
      valve_r     <= valve_nxt;
      thresh_r    <= thresh_nxt;
      pip_avg_r   <= pip_avg_nxt;
      peep_avg_r  <= peep_avg_nxt;
    end
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The valve time never leaves its working range.
  a_valve_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valve_r >= VALVE_MIN) && (valve_r <= VALVE_MAX))
    else $error("valve open time out of range");

  // The hold threshold never falls below its floor.
  a_thresh_floor: assert property (@(posedge clk) disable iff (!rst_n)
    thresh_r >= THRESH_FLOOR)
    else $error("hold threshold below floor");

  // A mean arrives only while the sequencer waits for one.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_PIP_WAIT || state_r == ST_PEEP_WAIT))
    else $error("mean unit finished outside a wait state");

  // A new result is only ever loaded from the final sequencer state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

endmodule
